// ----- hw/rtl/esf_pkg.sv -----
`default_nettype none

package esf_pkg;

  localparam int MAX_TERMS = 32;
  localparam int ADDR_W    = $clog2(MAX_TERMS);
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);

  localparam int VALUE_W  = 32;
  localparam int COEFF_W  = 64;
  localparam int DEGREE_W = 6;

  localparam logic [COEFF_W-1:0] ONE_Q24 = 64'h0000_0000_0100_0000;
  localparam logic [COEFF_W-1:0] SAT_MAX = {COEFF_W{1'b1}};

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MULHI = 7'b0000010,
    S_MULLO = 7'b0000100,
    S_SCALE = 7'b0001000,
    S_ACCUM = 7'b0010000,
    S_EMIT0 = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/esf_ram.sv -----
`default_nettype none

module esf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/elementary_symmetric_functions.sv -----
`default_nettype none

// Elementary symmetric coefficients e0..en of a set of unsigned Q16.16
// values, kept as unsigned Q40.24 and saturated at all ones.
//
// Input: a transaction is taken when start is high and busy is low. Each
// transaction carries value, has_value and last. An element updates the
// stored coefficients highest degree first, e_k += x * e_(k-1), through one
// shared 32x32 multiplier and two 64-bit adders (scale, accumulate). Each
// coefficient takes four steps (high partial product, low partial product,
// scale, accumulate); an element of a set with n stored elements updates n+1
// coefficients. A dropped element or an item without value costs nothing.
//
// Output: on an item with last set, e0..en are emitted on consecutive cycles
// once the update ends (or after acceptance), registered through the EMIT0
// and EMIT states, each for one cycle with strobe high; final_res marks e_n.
// The receiver cannot stall the block. The store then starts over empty.
//
// Reset: rst clears the element count, the overflow flag and the sequencer.
// The coefficient memory needs no clearing: entries at or above the element
// count are never used.

module elementary_symmetric_functions
  import esf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [VALUE_W-1:0]  value,
  input  wire logic                has_value,
  input  wire logic                last,
  output logic                     strobe,
  output logic [DEGREE_W-1:0]      degree,
  output logic [COEFF_W-1:0]       coefficient,
  output logic                     overflow,
  output logic                     final_res
);

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   out_k;
  logic               ovf;
  logic               last_reg;
  logic [VALUE_W-1:0] x;
  logic [COEFF_W-1:0] op;
  logic [COEFF_W-1:0] cur;
  logic [COEFF_W-1:0] hi;
  logic [COEFF_W-1:0] prod;
  logic [COEFF_W-1:0] p;

  logic               accept;
  logic               take_elem;
  logic [CNT_W-1:0]   count_m1;
  logic [CNT_W-1:0]   k_m3;
  logic [COEFF_W-1:0] mul_a_op;
  logic [COEFF_W-1:0] mul_b;
  logic [COEFF_W-1:0] mul_out;
  logic [COEFF_W:0]   scale_sum;
  logic               scale_sat;
  logic [COEFF_W:0]   acc_sum;
  logic [COEFF_W-1:0] acc_val;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [COEFF_W-1:0] ram_rdata;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign take_elem = has_value && (count < CNT_W'(MAX_TERMS));
  assign count_m1  = count - CNT_W'(1);
  assign k_m3      = k - CNT_W'(3);

  // Shared multiplier: high half of the operand, then the low half.
  assign mul_a_op = (k == CNT_W'(1)) ? ONE_Q24 : ram_rdata;
  assign mul_b    = (state == S_MULHI) ? {32'b0, mul_a_op[63:32]} : {32'b0, op[31:0]};
  assign mul_out  = {32'b0, x} * mul_b;

  // Q56.40 product back to Q40.24, saturating.
  assign scale_sum = {1'b0, hi[47:0], 16'b0} + {17'b0, prod[63:16]};
  assign scale_sat = (|hi[63:48]) || scale_sum[COEFF_W];

  assign acc_sum = {1'b0, cur} + {1'b0, p};
  assign acc_val = acc_sum[COEFF_W] ? SAT_MAX : acc_sum[COEFF_W-1:0];

  assign ram_we    = (state == S_ACCUM);
  assign ram_waddr = count_m1[ADDR_W-1:0] - (count[ADDR_W-1:0] - k[ADDR_W-1:0]);

  always_comb begin
    ram_raddr = out_k[ADDR_W-1:0];
    unique case (state)
      S_IDLE:  ram_raddr = count_m1[ADDR_W-1:0];
      S_ACCUM: ram_raddr = k_m3[ADDR_W-1:0];
      S_EMIT0: ram_raddr = '0;
      default: ram_raddr = out_k[ADDR_W-1:0];
    endcase
  end

  esf_ram #(
    .WIDTH(COEFF_W),
    .DEPTH(MAX_TERMS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(acc_val),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (take_elem) begin
            state_next = S_MULHI;
          end else if (last) begin
            state_next = S_EMIT0;
          end
        end
      end
      S_MULHI: state_next = S_MULLO;
      S_MULLO: state_next = S_SCALE;
      S_SCALE: state_next = S_ACCUM;
      S_ACCUM: begin
        if (k == CNT_W'(1)) begin
          state_next = last_reg ? S_EMIT0 : S_IDLE;
        end else begin
          state_next = S_MULHI;
        end
      end
      S_EMIT0: state_next = (count == '0) ? S_IDLE : S_EMIT;
      S_EMIT:  state_next = (out_k == count) ? S_IDLE : S_EMIT;
      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      ovf    <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == S_EMIT0) || (state == S_EMIT);
      unique case (state)
        S_IDLE: begin
          if (accept && has_value) begin
            if (take_elem) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        S_SCALE: begin
          if (scale_sat) begin
            ovf <= 1'b1;
          end
        end
        S_ACCUM: begin
          if (acc_sum[COEFF_W]) begin
            ovf <= 1'b1;
          end
        end
        S_EMIT0: begin
          if (count == '0) begin
            ovf <= 1'b0;
          end
        end
        S_EMIT: begin
          // drop the set once its highest coefficient goes out
          if (out_k == count) begin
            count <= '0;
            ovf   <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          x        <= value;
          last_reg <= last;
          k        <= count + CNT_W'(1);
          cur      <= '0;
        end
      end
      S_MULHI: begin
        op   <= mul_a_op;
        prod <= mul_out;
      end
      S_MULLO: begin
        hi   <= prod;
        prod <= mul_out;
      end
      S_SCALE: begin
        p <= scale_sat ? SAT_MAX : scale_sum[COEFF_W-1:0];
      end
      S_ACCUM: begin
        // old e_(k-1) becomes the addend of the next lower degree
        cur <= op;
        k   <= k - CNT_W'(1);
      end
      S_EMIT0: begin
        degree      <= '0;
        coefficient <= ONE_Q24;
        overflow    <= ovf;
        final_res   <= (count == '0);
        out_k       <= CNT_W'(1);
      end
      S_EMIT: begin
        degree      <= DEGREE_W'(out_k);
        coefficient <= ram_rdata;
        overflow    <= ovf;
        final_res   <= (out_k == count);
        out_k       <= out_k + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
